// ===== rtl/convex_polyhedron_point_filter_top_defines.svh =====
// assertion helpers for the point filter
`ifndef CONVEX_POLYHEDRON_POINT_FILTER_TOP_DEFINES_SVH
`define CONVEX_POLYHEDRON_POINT_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CPF_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpf check failed");

// next-cycle implication, checked out of reset
`define CPF_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpf check failed");

`endif

// ===== rtl/cpf_pkg.sv =====
package cpf_pkg;

  // field widths
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 5;
  localparam int NORM_W     = 18;
  localparam int COORD_W    = 28;
  localparam int CNT_W      = 6;
  localparam int FC_W       = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // parameter defaults
  localparam int MAX_FACES_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // reset values
  localparam logic [FC_W-1:0] FACE_COUNT_RST = FC_W'(4);

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_REF  = 2'd1,
    CMD_TEST = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACE_COUNT = 3'd0,
    CFG_BOX_MIN_X  = 3'd1,
    CFG_BOX_MAX_X  = 3'd2,
    CFG_BOX_MIN_Y  = 3'd3,
    CFG_BOX_MAX_Y  = 3'd4,
    CFG_BOX_MIN_Z  = 3'd5,
    CFG_BOX_MAX_Z  = 3'd6
  } cfg_idx_t;

  // one face plane
  typedef struct packed {
    logic signed [NORM_W-1:0]  a;
    logic signed [NORM_W-1:0]  b;
    logic signed [NORM_W-1:0]  c;
    logic signed [COORD_W-1:0] d;
  } face_t;

  // point moving along the cell row
  typedef struct packed {
    logic                      valid;
    logic                      is_test;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pnt_tok_t;

  // running mismatch count moving along the cell row
  typedef struct packed {
    logic             valid;
    logic             is_test;
    logic [CNT_W-1:0] count;
  } res_tok_t;

endpackage

// ===== rtl/cpf_if.sv =====
// input channel: one command beat
interface cpf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [cpf_pkg::CMD_W-1:0]              cmd;
  logic [cpf_pkg::IDX_W-1:0]              face_index;
  logic signed [cpf_pkg::NORM_W-1:0]      normal_a;
  logic signed [cpf_pkg::NORM_W-1:0]      normal_b;
  logic signed [cpf_pkg::NORM_W-1:0]      normal_c;
  logic signed [cpf_pkg::COORD_W-1:0]     plane_offset;
  logic signed [cpf_pkg::COORD_W-1:0]     point_x;
  logic signed [cpf_pkg::COORD_W-1:0]     point_y;
  logic signed [cpf_pkg::COORD_W-1:0]     point_z;

  modport source (
    output valid, cmd, face_index, normal_a, normal_b, normal_c, plane_offset,
           point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, face_index, normal_a, normal_b, normal_c, plane_offset,
           point_x, point_y, point_z,
    output ready
  );
endinterface

// result channel: one verdict beat
interface cpf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       inside_res;
  logic                       in_box;
  logic [cpf_pkg::CNT_W-1:0]  mismatch_count;

  modport source (output valid, inside_res, in_box, mismatch_count, input ready);
  modport sink   (input valid, inside_res, in_box, mismatch_count, output ready);
endinterface

// ===== rtl/convex_polyhedron_point_filter_top.sv =====
// channel   dir  beat                                    handshake
// in_ch     in   cmd, face slot, plane, point            valid/ready
// out_ch    out  inside_res, in_box, mismatch_count      valid/ready
// cfg_*     in   register index, data                    write enable only
//
// a load beat is written in the cycle it is taken; the next beat may follow at once
// a reference or test beat walks the row of MAX_FACES cells, one cell per cycle,
// two stages per cell; no other beat is taken while it is in the row or parked
// a finished verdict waits in the output register; one more is parked while it stalls
// synchronous active-low reset clears the reference signs and the control registers
`include "convex_polyhedron_point_filter_top_defines.svh"

module convex_polyhedron_point_filter_top #(
  parameter int MAX_FACES = cpf_pkg::MAX_FACES_DEF,
  parameter int FRAC_BITS = cpf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cpf_in_if.sink                            in_ch,
  cpf_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [cpf_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [cpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NU_W = $clog2(MAX_FACES + 1);

  logic [cpf_pkg::FC_W-1:0]           face_count_r;
  logic signed [cpf_pkg::COORD_W-1:0] box_min_x_r, box_max_x_r;
  logic signed [cpf_pkg::COORD_W-1:0] box_min_y_r, box_max_y_r;
  logic signed [cpf_pkg::COORD_W-1:0] box_min_z_r, box_max_z_r;

  logic                       busy_r;
  logic                       in_box_r;
  cpf_pkg::pnt_tok_t          tok0_r;
  logic                       out_valid_r;
  logic                       out_inside_r;
  logic                       out_in_box_r;
  logic [cpf_pkg::CNT_W-1:0]  out_count_r;
  logic                       pend_valid_r;
  logic                       pend_in_box_r;
  logic [cpf_pkg::CNT_W-1:0]  pend_count_r;

  logic                       in_acc;
  logic                       walk_acc;
  logic                       load_en;
  logic                       box_ok;
  logic                       out_free;
  logic                       done_test;
  logic                       done_ref;
  logic [NU_W-1:0]            n_use;
  cpf_pkg::face_t             wr_face;
  cpf_pkg::pnt_tok_t          tok_chain [MAX_FACES];
  cpf_pkg::pnt_tok_t          tok_tail;
  cpf_pkg::res_tok_t          res_chain [MAX_FACES];
  cpf_pkg::res_tok_t          res_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_count_r <= cpf_pkg::FACE_COUNT_RST;
      box_min_x_r  <= '0;
      box_max_x_r  <= '0;
      box_min_y_r  <= '0;
      box_max_y_r  <= '0;
      box_min_z_r  <= '0;
      box_max_z_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        cpf_pkg::CFG_FACE_COUNT: face_count_r <= cfg_data[cpf_pkg::FC_W-1:0];
        cpf_pkg::CFG_BOX_MIN_X:  box_min_x_r  <= signed'(cfg_data);
        cpf_pkg::CFG_BOX_MAX_X:  box_max_x_r  <= signed'(cfg_data);
        cpf_pkg::CFG_BOX_MIN_Y:  box_min_y_r  <= signed'(cfg_data);
        cpf_pkg::CFG_BOX_MAX_Y:  box_max_y_r  <= signed'(cfg_data);
        cpf_pkg::CFG_BOX_MIN_Z:  box_min_z_r  <= signed'(cfg_data);
        cpf_pkg::CFG_BOX_MAX_Z:  box_max_z_r  <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // faces in use, clipped to the row length
  always_comb begin
    if (int'(face_count_r) > MAX_FACES) begin
      n_use = NU_W'(MAX_FACES);
    end else begin
      n_use = NU_W'(face_count_r);
    end
  end

  // input decode
  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;
  assign load_en     = in_acc && (in_ch.cmd == cpf_pkg::CMD_LOAD);
  assign walk_acc    = in_acc && ((in_ch.cmd == cpf_pkg::CMD_REF) ||
                                  (in_ch.cmd == cpf_pkg::CMD_TEST));

  assign wr_face.a = in_ch.normal_a;
  assign wr_face.b = in_ch.normal_b;
  assign wr_face.c = in_ch.normal_c;
  assign wr_face.d = in_ch.plane_offset;

  // strict bounding box test
  assign box_ok = (in_ch.point_x > box_min_x_r) && (in_ch.point_x < box_max_x_r) &&
                  (in_ch.point_y > box_min_y_r) && (in_ch.point_y < box_max_y_r) &&
                  (in_ch.point_z > box_min_z_r) && (in_ch.point_z < box_max_z_r);

  // launch register feeding the first cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r <= '0;
    end else begin
      tok0_r.valid   <= walk_acc;
      tok0_r.is_test <= (in_ch.cmd == cpf_pkg::CMD_TEST);
      tok0_r.x       <= in_ch.point_x;
      tok0_r.y       <= in_ch.point_y;
      tok0_r.z       <= in_ch.point_z;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_acc) begin
      in_box_r <= box_ok;
    end
  end

  // row of face cells
  assign tok_chain[0] = tok0_r;

  for (genvar i = 0; i < MAX_FACES; i++) begin : g_cell
    logic [cpf_pkg::CNT_W-1:0] cnt_in;
    logic                      wr_en;

    assign wr_en = load_en &&
                   ((cpf_pkg::IDX_W + 1)'(in_ch.face_index) == (cpf_pkg::IDX_W + 1)'(i));

    if (i == 0) begin : g_head
      assign cnt_in = '0;
    end else begin : g_body
      assign cnt_in = res_chain[i-1].count;
    end

    if (i == MAX_FACES - 1) begin : g_last
      cpf_cell #(.IDX(i), .MAX_FACES(MAX_FACES), .FRAC_BITS(FRAC_BITS)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_face (wr_face),
        .n_use   (n_use),
        .tok_in  (tok_chain[i]),
        .tok_out (tok_tail),
        .cnt_in  (cnt_in),
        .res_out (res_chain[i])
      );
    end else begin : g_mid
      cpf_cell #(.IDX(i), .MAX_FACES(MAX_FACES), .FRAC_BITS(FRAC_BITS)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_face (wr_face),
        .n_use   (n_use),
        .tok_in  (tok_chain[i]),
        .tok_out (tok_chain[i+1]),
        .cnt_in  (cnt_in),
        .res_out (res_chain[i])
      );
    end
  end

  assign res_end   = res_chain[MAX_FACES-1];
  assign done_test = res_end.valid && res_end.is_test;
  assign done_ref  = res_end.valid && !res_end.is_test;
  assign out_free  = !out_valid_r || out_ch.ready;

  // output register with one parking slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= done_test;
      end
    end else if (done_test) begin
      pend_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid_r) begin
        out_inside_r <= pend_in_box_r && (pend_count_r == '0);
        out_in_box_r <= pend_in_box_r;
        out_count_r  <= pend_count_r;
      end else begin
        out_inside_r <= in_box_r && (res_end.count == '0);
        out_in_box_r <= in_box_r;
        out_count_r  <= res_end.count;
      end
    end
    if (!out_free && done_test) begin
      pend_in_box_r <= in_box_r;
      pend_count_r  <= res_end.count;
    end
  end

  // one reference or test beat in the row at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (walk_acc) begin
      busy_r <= 1'b1;
    end else if (done_ref || (out_free && (done_test || pend_valid_r))) begin
      busy_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.inside_res     = out_inside_r;
  assign out_ch.in_box         = out_in_box_r;
  assign out_ch.mismatch_count = out_count_r;

  // checks
  `CPF_CHECK_NOW(a_done_while_busy, res_end.valid, busy_r)
  `CPF_CHECK_NOW(a_park_behind_out, pend_valid_r, out_valid_r && busy_r)
  `CPF_CHECK_NEXT(a_launch, walk_acc, tok0_r.valid)
  `CPF_CHECK_NEXT(a_tail_to_result, tok_tail.valid, res_end.valid)

endmodule

// ===== rtl/cpf_cell.sv =====
module cpf_cell #(
  parameter int  IDX       = 0,
  parameter int  MAX_FACES = cpf_pkg::MAX_FACES_DEF,
  parameter int  FRAC_BITS = cpf_pkg::FRAC_BITS_DEF,
  localparam int NU_W      = $clog2(MAX_FACES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  cpf_pkg::face_t                 wr_face,
  input  logic [NU_W-1:0]                n_use,
  input  cpf_pkg::pnt_tok_t              tok_in,
  output cpf_pkg::pnt_tok_t              tok_out,
  input  logic [cpf_pkg::CNT_W-1:0]      cnt_in,
  output cpf_pkg::res_tok_t              res_out
);

  localparam int PROD_W = cpf_pkg::NORM_W + cpf_pkg::COORD_W;
  localparam int OFF_W  = cpf_pkg::COORD_W + FRAC_BITS;
  localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;
  localparam logic [NU_W-1:0] IDX_V = NU_W'(IDX);

  cpf_pkg::face_t            face_r;
  logic                      ref_sign_r;
  cpf_pkg::pnt_tok_t         tok_r;
  logic signed [PROD_W-1:0]  pa_r, pb_r, pc_r;
  logic                      st_valid_r;
  logic                      st_test_r;
  cpf_pkg::res_tok_t         res_r;

  logic signed [SUM_W-1:0]   d_ext;
  logic signed [SUM_W-1:0]   sum;
  logic                      active;
  logic                      pos;
  logic                      mism;
  logic [cpf_pkg::CNT_W-1:0] cnt_nxt;

  // face plane storage, written only by a load beat for this slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      face_r <= wr_face;
    end
  end

  // stage one: three products, point handed on to the next cell
  always_ff @(posedge clk) begin
    pa_r <= face_r.a * tok_in.x;
    pb_r <= face_r.b * tok_in.y;
    pc_r <= face_r.c * tok_in.z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r      <= '0;
      st_valid_r <= 1'b0;
      st_test_r  <= 1'b0;
    end else begin
      tok_r      <= tok_in;
      st_valid_r <= tok_in.valid;
      st_test_r  <= tok_in.is_test;
    end
  end

  // stage two: exact plane value and its sign
  always_comb begin
    d_ext  = SUM_W'(face_r.d);
    sum    = SUM_W'(pa_r) + SUM_W'(pb_r) + SUM_W'(pc_r) + (d_ext <<< FRAC_BITS);
    pos    = !sum[SUM_W-1] && (sum != '0);
    active = (IDX_V < n_use);
    mism   = active && (pos != ref_sign_r);
  end

  // saturating count update
  always_comb begin
    if (st_test_r && mism && (cnt_in != '1)) begin
      cnt_nxt = cnt_in + 1'b1;
    end else begin
      cnt_nxt = cnt_in;
    end
  end

  // reference sign and count hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_sign_r <= 1'b0;
      res_r      <= '0;
    end else begin
      if (st_valid_r && !st_test_r) begin
        ref_sign_r <= active && pos;
      end
      res_r.valid   <= st_valid_r;
      res_r.is_test <= st_test_r;
      res_r.count   <= cnt_nxt;
    end
  end

  assign tok_out = tok_r;
  assign res_out = res_r;

endmodule

// ===== tb/convex_polyhedron_point_filter_top_tb.sv =====
`timescale 1ns / 100ps

module convex_polyhedron_point_filter_top_tb;

  localparam int MAX_FACES     = cpf_pkg::MAX_FACES_DEF;
  localparam int FRAC_BITS     = cpf_pkg::FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = MAX_FACES + 16;
  localparam int ITEM_TARGET   = 1600;
  localparam int CALM_FROM     = 1350;

  // command code the block ignores
  localparam logic [cpf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [cpf_pkg::COORD_W-1:0] COORD_MAX =
    {1'b0, {(cpf_pkg::COORD_W-1){1'b1}}};
  localparam logic signed [cpf_pkg::COORD_W-1:0] COORD_MIN =
    {1'b1, {(cpf_pkg::COORD_W-1){1'b0}}};
  localparam logic signed [cpf_pkg::NORM_W-1:0]  NORM_MAX  =
    {1'b0, {(cpf_pkg::NORM_W-1){1'b1}}};
  localparam logic signed [cpf_pkg::NORM_W-1:0]  NORM_MIN  =
    {1'b1, {(cpf_pkg::NORM_W-1){1'b0}}};

  typedef struct {
    logic [cpf_pkg::CMD_W-1:0]          cmd;
    logic [cpf_pkg::IDX_W-1:0]          face_index;
    logic signed [cpf_pkg::NORM_W-1:0]  a;
    logic signed [cpf_pkg::NORM_W-1:0]  b;
    logic signed [cpf_pkg::NORM_W-1:0]  c;
    logic signed [cpf_pkg::COORD_W-1:0] d;
    logic signed [cpf_pkg::COORD_W-1:0] x;
    logic signed [cpf_pkg::COORD_W-1:0] y;
    logic signed [cpf_pkg::COORD_W-1:0] z;
  } filter_beat_t;

  typedef struct {
    logic                      inside_res;
    logic                      in_box;
    logic [cpf_pkg::CNT_W-1:0] mismatch_count;
  } verdict_t;

  // cell predictor and the queue of verdicts it expects
  class cell_scoreboard;
    logic signed [cpf_pkg::NORM_W-1:0]  plane_a[MAX_FACES];
    logic signed [cpf_pkg::NORM_W-1:0]  plane_b[MAX_FACES];
    logic signed [cpf_pkg::NORM_W-1:0]  plane_c[MAX_FACES];
    logic signed [cpf_pkg::COORD_W-1:0] plane_d[MAX_FACES];
    logic [MAX_FACES-1:0]               ref_signs;
    logic [cpf_pkg::FC_W-1:0]           face_count;
    logic signed [cpf_pkg::COORD_W-1:0] box_lo[3];
    logic signed [cpf_pkg::COORD_W-1:0] box_hi[3];
    verdict_t                           verdicts[$];
    int                                 failures;
    int                                 beats;
    int                                 results;
    int                                 inside_hits;
    int                                 box_hits;

    function new();
      foreach (plane_a[f]) begin
        plane_a[f] = '0;
        plane_b[f] = '0;
        plane_c[f] = '0;
        plane_d[f] = '0;
      end
      foreach (box_lo[k]) begin
        box_lo[k] = '0;
        box_hi[k] = '0;
      end
      ref_signs   = '0;
      face_count  = cpf_pkg::FACE_COUNT_RST;
      failures    = 0;
      beats       = 0;
      results     = 0;
      inside_hits = 0;
      box_hits    = 0;
    endfunction

    function void set_register(cpf_pkg::cfg_idx_t idx, logic [cpf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cpf_pkg::CFG_FACE_COUNT: face_count = data[cpf_pkg::FC_W-1:0];
        cpf_pkg::CFG_BOX_MIN_X:  box_lo[0] = data;
        cpf_pkg::CFG_BOX_MAX_X:  box_hi[0] = data;
        cpf_pkg::CFG_BOX_MIN_Y:  box_lo[1] = data;
        cpf_pkg::CFG_BOX_MAX_Y:  box_hi[1] = data;
        cpf_pkg::CFG_BOX_MIN_Z:  box_lo[2] = data;
        cpf_pkg::CFG_BOX_MAX_Z:  box_hi[2] = data;
        default: ;
      endcase
    endfunction

    // face count saturates at the table depth
    function int faces_used();
      int n;
      n = int'(face_count);
      return (n > MAX_FACES) ? MAX_FACES : n;
    endfunction

    // one bit per face in use: plane value strictly positive, exact in 64 bits
    function logic [MAX_FACES-1:0] face_signs(logic signed [cpf_pkg::COORD_W-1:0] x, y, z);
      logic [MAX_FACES-1:0] bits;
      longint               acc;
      bits = '0;
      for (int f = 0; f < faces_used(); f++) begin
        acc = longint'(plane_a[f]) * longint'(x) + longint'(plane_b[f]) * longint'(y)
            + longint'(plane_c[f]) * longint'(z) + (longint'(plane_d[f]) <<< FRAC_BITS);
        bits[f] = (acc > 0);
      end
      return bits;
    endfunction

    function void note_beat(filter_beat_t beat);
      verdict_t             v;
      logic [MAX_FACES-1:0] diff;
      logic                 box_ok;
      int                   cnt;
      if (beat.cmd != CMD_UNUSED) beats++;
      case (beat.cmd)
        cpf_pkg::CMD_LOAD: begin
          plane_a[beat.face_index] = beat.a;
          plane_b[beat.face_index] = beat.b;
          plane_c[beat.face_index] = beat.c;
          plane_d[beat.face_index] = beat.d;
        end
        cpf_pkg::CMD_REF: ref_signs = face_signs(beat.x, beat.y, beat.z);
        cpf_pkg::CMD_TEST: begin
          box_ok = beat.x > box_lo[0] && beat.x < box_hi[0] &&
                   beat.y > box_lo[1] && beat.y < box_hi[1] &&
                   beat.z > box_lo[2] && beat.z < box_hi[2];
          diff = face_signs(beat.x, beat.y, beat.z) ^ ref_signs;
          cnt = 0;
          for (int f = 0; f < faces_used(); f++) cnt += int'(diff[f]);
          v.inside_res     = box_ok && (cnt == 0);
          v.in_box         = box_ok;
          v.mismatch_count = cpf_pkg::CNT_W'(cnt);
          verdicts.push_back(v);
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts.size() == 0) begin
        failures++;
        $error("verdict with nothing pending: inside_res %0d in_box %0d mismatch_count %0d",
               got.inside_res, got.in_box, got.mismatch_count);
        return;
      end
      want = verdicts.pop_front();
      results++;
      if (want.inside_res) inside_hits++;
      if (want.in_box) box_hits++;
      if (got.inside_res !== want.inside_res) begin
        failures++;
        $error("inside_res: expected %0d, actual %0d", want.inside_res, got.inside_res);
      end
      if (got.in_box !== want.in_box) begin
        failures++;
        $error("in_box: expected %0d, actual %0d", want.in_box, got.in_box);
      end
      if (got.mismatch_count !== want.mismatch_count) begin
        failures++;
        $error("mismatch_count: expected %0d, actual %0d",
               want.mismatch_count, got.mismatch_count);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [cpf_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [cpf_pkg::CFG_DATA_W-1:0] cfg_data;

  cpf_in_if  cmd_ch();
  cpf_out_if verdict_ch();

  cell_scoreboard sb;
  int             gap_odds = 0;
  int             stall_odds = 0;
  int             settings_done = 0;
  bit             calm = 1'b0;

  convex_polyhedron_point_filter_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_ch),
    .out_ch   (verdict_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // drive one command beat and wait for it to be taken
  task automatic send_beat(input filter_beat_t beat);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.cmd          <= beat.cmd;
    cmd_ch.face_index   <= beat.face_index;
    cmd_ch.normal_a     <= beat.a;
    cmd_ch.normal_b     <= beat.b;
    cmd_ch.normal_c     <= beat.c;
    cmd_ch.plane_offset <= beat.d;
    cmd_ch.point_x      <= beat.x;
    cmd_ch.point_y      <= beat.y;
    cmd_ch.point_z      <= beat.z;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    sb.note_beat(beat);
  endtask

  // drain: every verdict in, then let a trailing reference beat finish
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cpf_pkg::cfg_idx_t idx,
                           input logic [cpf_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic program_regs(input logic [cpf_pkg::FC_W-1:0] fc,
                              input logic signed [cpf_pkg::COORD_W-1:0] lo_x, hi_x, lo_y, hi_y,
                              input logic signed [cpf_pkg::COORD_W-1:0] lo_z, hi_z);
    write_reg(cpf_pkg::CFG_FACE_COUNT, cpf_pkg::CFG_DATA_W'(fc));
    write_reg(cpf_pkg::CFG_BOX_MIN_X, lo_x);
    write_reg(cpf_pkg::CFG_BOX_MAX_X, hi_x);
    write_reg(cpf_pkg::CFG_BOX_MIN_Y, lo_y);
    write_reg(cpf_pkg::CFG_BOX_MAX_Y, hi_y);
    write_reg(cpf_pkg::CFG_BOX_MIN_Z, lo_z);
    write_reg(cpf_pkg::CFG_BOX_MAX_Z, hi_z);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // every field random, the command fixed
  function automatic filter_beat_t noise_beat(logic [cpf_pkg::CMD_W-1:0] cmd);
    filter_beat_t beat;
    beat.cmd        = cmd;
    beat.face_index = cpf_pkg::IDX_W'($urandom);
    beat.a          = cpf_pkg::NORM_W'($urandom);
    beat.b          = cpf_pkg::NORM_W'($urandom);
    beat.c          = cpf_pkg::NORM_W'($urandom);
    beat.d          = cpf_pkg::COORD_W'($urandom);
    beat.x          = cpf_pkg::COORD_W'($urandom);
    beat.y          = cpf_pkg::COORD_W'($urandom);
    beat.z          = cpf_pkg::COORD_W'($urandom);
    return beat;
  endfunction

  function automatic filter_beat_t point_beat(logic [cpf_pkg::CMD_W-1:0] cmd,
                                              logic signed [cpf_pkg::COORD_W-1:0] x, y, z);
    filter_beat_t beat;
    beat   = noise_beat(cmd);
    beat.x = x;
    beat.y = y;
    beat.z = z;
    return beat;
  endfunction

  function automatic filter_beat_t plane_beat(int slot,
                                              logic signed [cpf_pkg::NORM_W-1:0] a, b, c,
                                              logic signed [cpf_pkg::COORD_W-1:0] d);
    filter_beat_t beat;
    beat            = noise_beat(cpf_pkg::CMD_LOAD);
    beat.face_index = cpf_pkg::IDX_W'(slot);
    beat.a          = a;
    beat.b          = b;
    beat.c          = c;
    beat.d          = d;
    return beat;
  endfunction

  // random normal, offset chosen so the plane passes near the cell center
  function automatic filter_beat_t plane_around(int slot,
                                                logic signed [cpf_pkg::COORD_W-1:0] cx, cy,
                                                logic signed [cpf_pkg::COORD_W-1:0] cz);
    filter_beat_t beat;
    longint       dot;
    longint       lean;
    beat            = noise_beat(cpf_pkg::CMD_LOAD);
    beat.face_index = cpf_pkg::IDX_W'(slot);
    dot  = longint'(beat.a) * longint'(cx) + longint'(beat.b) * longint'(cy)
         + longint'(beat.c) * longint'(cz);
    lean = longint'($urandom_range(0, 1 << 20));
    if ($urandom_range(0, 1) == 1) lean = -lean;
    beat.d = cpf_pkg::COORD_W'(lean - (dot >>> FRAC_BITS));
    return beat;
  endfunction

  // point close to a center, spread over many scales
  function automatic logic signed [cpf_pkg::COORD_W-1:0] jitter(
    logic signed [cpf_pkg::COORD_W-1:0] c);
    int span;
    int delta;
    span  = 1 << $urandom_range(2, 22);
    delta = int'($urandom_range(0, 2 * span)) - span;
    if ($urandom_range(0, 7) == 0) delta = 0;
    return cpf_pkg::COORD_W'(int'(c) + delta);
  endfunction

  task automatic run_directed();
    // reset state: four faces, empty box
    send_beat(plane_beat(0, NORM_MAX, NORM_MIN, '0, COORD_MAX));
    send_beat(plane_beat(1, NORM_MIN, NORM_MAX, NORM_MAX, COORD_MIN));
    send_beat(plane_beat(2, '0, '0, NORM_MIN, '0));
    send_beat(plane_beat(3, '0, '0, '0, '0));
    send_beat(noise_beat(CMD_UNUSED));
    send_beat(point_beat(cpf_pkg::CMD_REF, '0, '0, '0));
    send_beat(point_beat(cpf_pkg::CMD_TEST, '0, '0, '0));
    send_beat(point_beat(cpf_pkg::CMD_TEST, COORD_MAX, COORD_MAX, COORD_MAX));
    send_beat(point_beat(cpf_pkg::CMD_TEST, COORD_MIN, COORD_MIN, COORD_MIN));

    // widest box: the extremes themselves sit on the strict bounds
    settle();
    program_regs(4, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    send_beat(point_beat(cpf_pkg::CMD_TEST, '0, '0, '0));
    send_beat(point_beat(cpf_pkg::CMD_TEST, COORD_MAX, '0, '0));
    send_beat(point_beat(cpf_pkg::CMD_TEST, cpf_pkg::COORD_W'(COORD_MIN + 1),
                         cpf_pkg::COORD_W'(COORD_MAX - 1), 1));
    send_beat(point_beat(cpf_pkg::CMD_TEST, 1, -1, COORD_MIN));

    // no faces in use
    settle();
    program_regs(0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    send_beat(point_beat(cpf_pkg::CMD_TEST, 1000, -5000, 7));
    send_beat(point_beat(cpf_pkg::CMD_REF, COORD_MAX, COORD_MIN, COORD_MAX));
    send_beat(point_beat(cpf_pkg::CMD_TEST, -3, 3, 0));

    // inverted box
    settle();
    program_regs(4, 100, -100, 100, -100, 100, -100);
    send_beat(point_beat(cpf_pkg::CMD_TEST, '0, '0, '0));
    send_beat(point_beat(cpf_pkg::CMD_TEST, 50, -50, 0));
  endtask

  task automatic run_random();
    logic signed [cpf_pkg::COORD_W-1:0] ctr[3];
    logic signed [cpf_pkg::COORD_W-1:0] lo[3];
    logic signed [cpf_pkg::COORD_W-1:0] hi[3];
    logic [cpf_pkg::FC_W-1:0]           fc;
    int                                 pick;
    int                                 span;
    int                                 phase;
    phase = 0;
    while (sb.beats < ITEM_TARGET) begin
      // idling profile for this phase, none near the end
      calm       = (sb.beats >= CALM_FROM);
      gap_odds   = calm ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 8));
      stall_odds = calm ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 8));

      foreach (ctr[k])
        ctr[k] = cpf_pkg::COORD_W'(int'($urandom_range(0, 1 << 24)) - (1 << 23));

      // first phase fills the whole table and saturates the face count
      if (phase == 0) fc = 63;
      else begin
        pick = $urandom_range(0, 19);
        if (pick < 9) fc = cpf_pkg::FC_W'($urandom_range(1, 32));
        else if (pick < 12) fc = 32;
        else if (pick < 14) fc = 0;
        else if (pick < 16) fc = cpf_pkg::FC_W'($urandom_range(1, 4));
        else fc = cpf_pkg::FC_W'($urandom_range(33, 63));
      end

      // box mostly around the cell, sometimes widest, empty or arbitrary
      pick = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
        span = 1 << $urandom_range(8, 23);
        if (pick < 7) begin
          lo[k] = cpf_pkg::COORD_W'(int'(ctr[k]) - span);
          hi[k] = cpf_pkg::COORD_W'(int'(ctr[k]) + span);
        end else if (pick == 7) begin
          lo[k] = COORD_MIN;
          hi[k] = COORD_MAX;
        end else if (pick == 8) begin
          lo[k] = ctr[k];
          hi[k] = ctr[k];
        end else begin
          lo[k] = cpf_pkg::COORD_W'($urandom);
          hi[k] = cpf_pkg::COORD_W'($urandom);
        end
      end

      settle();
      program_regs(fc, lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);

      // faces, reference at the center, then test points among random noise beats
      for (int f = 0; f < MAX_FACES; f++)
        if (phase == 0 || (f < fc && $urandom_range(0, 9) != 0))
          send_beat(plane_around(f, ctr[0], ctr[1], ctr[2]));
      send_beat(point_beat(cpf_pkg::CMD_REF, ctr[0], ctr[1], ctr[2]));
      repeat ($urandom_range(20, 50)) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_beat(noise_beat(CMD_UNUSED));
        else if (pick == 1) send_beat(noise_beat(cpf_pkg::CMD_LOAD));
        else if (pick == 2) send_beat(noise_beat(cpf_pkg::CMD_REF));
        else if (pick == 3) send_beat(noise_beat(cpf_pkg::CMD_TEST));
        else send_beat(point_beat(cpf_pkg::CMD_TEST, jitter(ctr[0]), jitter(ctr[1]),
                                  jitter(ctr[2])));
      end
      phase++;
    end
  endtask

  // result side: check each beat, stall in random bursts
  initial begin : verdict_sink
    int       stall_left;
    verdict_t got;
    stall_left = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
        got.inside_res     = verdict_ch.inside_res;
        got.in_box         = verdict_ch.in_box;
        got.mismatch_count = verdict_ch.mismatch_count;
        sb.check_verdict(got);
      end
      if (stall_left > 0) stall_left--;
      else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        stall_left = $urandom_range(1, 15);
      verdict_ch.ready <= (stall_left == 0);
    end
  end

  initial begin : stimulus
    sb = new();
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= '0;
    cfg_data            <= '0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.cmd          <= '0;
    cmd_ch.face_index   <= '0;
    cmd_ch.normal_a     <= '0;
    cmd_ch.normal_b     <= '0;
    cmd_ch.normal_c     <= '0;
    cmd_ch.plane_offset <= '0;
    cmd_ch.point_x      <= '0;
    cmd_ch.point_y      <= '0;
    cmd_ch.point_z      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();
    settle();

    $display("covered %0d commands across %0d register settings", sb.beats, settings_done);
    $display("checked %0d verdicts: %0d inside the cell, %0d inside the box",
             sb.results, sb.inside_hits, sb.box_hits);
    if (sb.failures == 0)
      $display("convex_polyhedron_point_filter_top_tb passed");
    else
      $display("convex_polyhedron_point_filter_top_tb failed");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("convex_polyhedron_point_filter_top_tb failed");
    $finish;
  end

endmodule
